>>> rtl/pid_turn_controller_core_assert.svh
// ----------------------------------------------------------------------------
// pid_turn_controller_core_assert.svh
// Assertion macros shared by the turn controller modules. Each macro samples
// on the rising edge of clock and is switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef PID_TURN_CONTROLLER_CORE_ASSERT_SVH
`define PID_TURN_CONTROLLER_CORE_ASSERT_SVH

// Condition that must hold at every edge
`define PTC_ASSERT_ALWAYS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequence in the same cycle as the antecedent
`define PTC_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the antecedent
`define PTC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Widths, register codes, reset values and shared types of the heading PID
// turn controller.
// ----------------------------------------------------------------------------
package ptc_pkg;

   // Field widths
   localparam int unsigned ANGLE_W     = 24;
   localparam int unsigned ERR_W       = 25;
   localparam int unsigned DERIV_W     = 26;
   localparam int unsigned SUM_W       = 40;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned GAIN_W      = 24;
   localparam int unsigned LIMIT_W     = 12;
   localparam int unsigned ZONE_W      = 23;
   localparam int unsigned DRIVE_W     = 13;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned CSR_INDEX_W = 3;

   // Default depth of the queue between front and back
   localparam int unsigned PTC_QUEUE_DEPTH = 2;

   // Fixed point: products are Q.24, drive is Q.8
   localparam int unsigned FRAC_SHIFT = 16;
   localparam int unsigned SUM_SPLIT  = 20;

   // Integral saturation bounds
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PROP_GAIN   = 3'd0,
      REG_INTEG_GAIN  = 3'd1,
      REG_DERIV_GAIN  = 3'd2,
      REG_DRIVE_LIMIT = 3'd3,
      REG_INTEG_ZONE  = 3'd4,
      REG_SETTLE_TOL  = 3'd5,
      REG_ITER_LIMIT  = 3'd6
   } ptc_reg_type;

   // Reset values of the registers
   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 24'd11796;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 24'd524;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 24'd6554;
   localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 12'd1536;
   localparam logic [ZONE_W-1:0]  INTEG_ZONE_RST  = 23'd4096;
   localparam logic [ZONE_W-1:0]  SETTLE_TOL_RST  = 23'd128;
   localparam logic [COUNT_W-1:0] ITER_LIMIT_RST  = 16'd300;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  integ_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [LIMIT_W-1:0] drive_limit;
      logic [ZONE_W-1:0]  integ_zone;
      logic [ZONE_W-1:0]  settle_tolerance;
      logic [COUNT_W-1:0] iteration_limit;
   } ptc_cfg_type;

   // Fields that ride along to the result unchanged
   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] iterations;
      logic [ERR_W-1:0]   err;
   } ptc_tag_type;

   // One classified request on its way to the back end
   typedef struct packed {
      ptc_tag_type        tag;
      logic [DERIV_W-1:0] deriv;
      logic [SUM_W-1:0]   err_sum;
   } ptc_item_type;

endpackage

>>> rtl/ptc_front.sv
// ----------------------------------------------------------------------------
// ptc_front
// Takes each request, forms the heading error, decides done, and updates the
// turn state (previous error, integral, iteration count) in the same cycle.
// ----------------------------------------------------------------------------
`include "pid_turn_controller_core_assert.svh"

module ptc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  ptc_pkg::ptc_cfg_type               cfg,
   input  logic                               accept,
   input  logic                               start_req,
   input  logic signed [ptc_pkg::ANGLE_W-1:0] target_angle,
   input  logic signed [ptc_pkg::ANGLE_W-1:0] measured_angle,
   output ptc_pkg::ptc_item_type              item
);
   import ptc_pkg::*;

   localparam int unsigned SUMX_W = SUM_W + 1;

   logic        [COUNT_W-1:0] count_ff, count_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [SUM_W-1:0]   err_sum_ff, err_sum_in;

   logic        [COUNT_W-1:0] base_count;
   logic signed [ERR_W-1:0]   base_prev;
   logic signed [SUM_W-1:0]   base_sum;
   logic signed [ERR_W-1:0]   err;
   logic        [ERR_W-1:0]   mag;
   logic                      done;
   logic                      in_zone;
   logic signed [DERIV_W-1:0] deriv;
   logic signed [SUMX_W-1:0]  sum_wide;
   logic signed [SUM_W-1:0]   sum_sat;
   logic        [COUNT_W-1:0] iter_next;
   logic signed [ERR_W-1:0]   prev_next;
   logic signed [SUM_W-1:0]   sum_next;

   // Classify the request and work out the next turn state
   always_comb begin
      base_count = start_req ? '0 : count_ff;
      base_prev  = start_req ? '0 : prev_err_ff;
      base_sum   = start_req ? '0 : err_sum_ff;

      err     = ERR_W'(target_angle) - ERR_W'(measured_angle);
      mag     = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
      done    = (mag <= ERR_W'(cfg.settle_tolerance)) ||
                (base_count >= cfg.iteration_limit);
      in_zone = (mag < ERR_W'(cfg.integ_zone)) && (err != '0);
      deriv   = DERIV_W'(err) - DERIV_W'(base_prev);

      // Accumulate and saturate the integral
      sum_wide = SUMX_W'(base_sum) + SUMX_W'(err);
      priority if (sum_wide[SUMX_W-1] && !sum_wide[SUMX_W-2]) begin
         sum_sat = SUM_MIN;
      end else if (!sum_wide[SUMX_W-1] && sum_wide[SUMX_W-2]) begin
         sum_sat = SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end

      // A done request leaves the state where it was, or cleared on a start
      if (done) begin
         iter_next = base_count;
         prev_next = base_prev;
         sum_next  = base_sum;
      end else begin
         iter_next = base_count + 1'b1;
         prev_next = err;
         sum_next  = in_zone ? sum_sat : '0;
      end

      count_in    = accept ? iter_next : count_ff;
      prev_err_in = accept ? prev_next : prev_err_ff;
      err_sum_in  = accept ? sum_next  : err_sum_ff;

      item.tag.done       = done;
      item.tag.iterations = iter_next;
      item.tag.err        = err;
      item.deriv          = deriv;
      item.err_sum        = sum_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         prev_err_ff <= '0;
         err_sum_ff  <= '0;
      end else begin
         count_ff    <= count_in;
         prev_err_ff <= prev_err_in;
         err_sum_ff  <= err_sum_in;
      end
   end

   `PTC_ASSERT_NEXT(a_done_keeps_state, accept && done && !start_req,
      $stable(count_ff) && $stable(prev_err_ff) && $stable(err_sum_ff),
      "done request changed the turn state")
   `PTC_ASSERT_NEXT(a_iteration_counts, accept && !done,
      count_ff == COUNT_W'($past(base_count) + 1'b1),
      "control step did not advance the iteration count by one")

endmodule

>>> rtl/ptc_queue.sv
// ----------------------------------------------------------------------------
// ptc_queue
// Short register queue that decouples the front end from the arithmetic
// back end, so each side can stall on its own.
// ----------------------------------------------------------------------------
`include "pid_turn_controller_core_assert.svh"

module ptc_queue #(
   parameter int unsigned DEPTH = ptc_pkg::PTC_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ptc_pkg::ptc_item_type push_item,
   output logic                  full,
   input  logic                  pop_ready,
   output logic                  valid,
   output ptc_pkg::ptc_item_type head_item
);
   import ptc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ptc_item_type       entry_ff [DEPTH];
   ptc_item_type       entry_in [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               take;

   assign full      = (count_ff == FULL_CNT);
   assign valid     = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign take      = valid && pop_ready;

   // Write at the tail, read from the head, keep the fill count
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_item;
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PTC_ASSERT_ALWAYS(a_count_range, count_ff <= FULL_CNT,
      "queue fill count above depth")
   `PTC_ASSERT_ALWAYS(a_no_overflow, !(push && full),
      "request pushed into a full queue")

endmodule

>>> rtl/ptc_back.sv
// ----------------------------------------------------------------------------
// ptc_back
// Arithmetic back end: gain products, integral term saturation, sum with
// round half up to Q.8, clamp to the drive limit and the result register.
// ----------------------------------------------------------------------------
`include "pid_turn_controller_core_assert.svh"

module ptc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  ptc_pkg::ptc_cfg_type             cfg,
   input  logic                             item_valid,
   input  ptc_pkg::ptc_item_type            item,
   output logic                             item_ready,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic signed [ptc_pkg::DRIVE_W-1:0] drive,
   output logic                             done_res,
   output logic [ptc_pkg::COUNT_W-1:0]      iterations,
   output logic signed [ptc_pkg::ERR_W-1:0] angle_error
);
   import ptc_pkg::*;

   localparam int unsigned P_W   = ERR_W + GAIN_W + 1;
   localparam int unsigned D_W   = DERIV_W + GAIN_W + 1;
   localparam int unsigned LO_W  = SUM_SPLIT + GAIN_W;
   localparam int unsigned HI_W  = SUM_W - SUM_SPLIT + GAIN_W + 1;
   localparam int unsigned IX_W  = HI_W + SUM_SPLIT;
   localparam int unsigned I_W   = 62;
   localparam int unsigned PD_W  = D_W + 2;
   localparam int unsigned TOT_W = I_W + 1;
   localparam int unsigned Q_W   = TOT_W - FRAC_SHIFT;
   localparam logic signed [IX_W-1:0] ITERM_HI = IX_W'(64'sd1152921504606846976);
   localparam logic signed [IX_W-1:0] ITERM_LO = -ITERM_HI;
   localparam logic signed [PD_W-1:0] ROUND_HALF = PD_W'(1) <<< (FRAC_SHIFT - 1);

   // Stage valids and handshake chain
   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in, out_v_ff, out_v_in;
   logic s1_ready, s2_ready, s3_ready, out_ready;

   // Stage payloads
   ptc_tag_type             s1_tag_ff, s1_tag_in, s2_tag_ff, s2_tag_in, s3_tag_ff, s3_tag_in;
   logic signed [P_W-1:0]   p_prod_ff, p_prod_in;
   logic signed [D_W-1:0]   d_prod_ff, d_prod_in;
   logic        [LO_W-1:0]  lo_prod_ff, lo_prod_in;
   logic signed [HI_W-1:0]  hi_prod_ff, hi_prod_in;
   logic signed [I_W-1:0]   iterm_ff, iterm_in;
   logic signed [PD_W-1:0]  pd_sum_ff, pd_sum_in;
   logic signed [Q_W-1:0]   quot_ff, quot_in;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;
   logic                    done_ff, done_in;
   logic [COUNT_W-1:0]      iter_ff, iter_in;
   logic signed [ERR_W-1:0] err_ff, err_in;

   logic signed [IX_W-1:0]  iterm_full;
   logic signed [TOT_W-1:0] total;
   logic signed [Q_W-1:0]   lim_pos;
   logic signed [Q_W-1:0]   clamped;

   // Advance a stage when the next one is free or moving
   always_comb begin
      out_ready  = !out_v_ff || rsp_tready;
      s3_ready   = !s3_v_ff || out_ready;
      s2_ready   = !s2_v_ff || s3_ready;
      s1_ready   = !s1_v_ff || s2_ready;
      item_ready = s1_ready;

      s1_v_in  = s1_ready  ? item_valid : s1_v_ff;
      s2_v_in  = s2_ready  ? s1_v_ff    : s2_v_ff;
      s3_v_in  = s3_ready  ? s2_v_ff    : s3_v_ff;
      out_v_in = out_ready ? s3_v_ff    : out_v_ff;
   end

   // Stage 1: gain products, integral split in two halves
   always_comb begin
      s1_tag_in  = s1_tag_ff;
      p_prod_in  = p_prod_ff;
      d_prod_in  = d_prod_ff;
      lo_prod_in = lo_prod_ff;
      hi_prod_in = hi_prod_ff;
      if (s1_ready) begin
         s1_tag_in  = item.tag;
         p_prod_in  = $signed(item.tag.err) * $signed({1'b0, cfg.prop_gain});
         d_prod_in  = $signed(item.deriv) * $signed({1'b0, cfg.deriv_gain});
         lo_prod_in = item.err_sum[SUM_SPLIT-1:0] * cfg.integ_gain;
         hi_prod_in = $signed(item.err_sum[SUM_W-1:SUM_SPLIT]) *
                      $signed({1'b0, cfg.integ_gain});
      end
   end

   // Stage 2: join and saturate the integral term, add P, D and the rounding half
   always_comb begin
      iterm_full = $signed({hi_prod_ff, SUM_SPLIT'(0)}) + $signed(IX_W'(lo_prod_ff));
      s2_tag_in  = s2_tag_ff;
      iterm_in   = iterm_ff;
      pd_sum_in  = pd_sum_ff;
      if (s2_ready) begin
         s2_tag_in = s1_tag_ff;
         priority if (iterm_full > ITERM_HI) begin
            iterm_in = I_W'(ITERM_HI);
         end else if (iterm_full < ITERM_LO) begin
            iterm_in = I_W'(ITERM_LO);
         end else begin
            iterm_in = I_W'(iterm_full);
         end
         pd_sum_in = PD_W'(p_prod_ff) + PD_W'(d_prod_ff) + ROUND_HALF;
      end
   end

   // Stage 3: full sum, floor to Q.8
   always_comb begin
      total     = TOT_W'(iterm_ff) + TOT_W'(pd_sum_ff);
      s3_tag_in = s3_tag_ff;
      quot_in   = quot_ff;
      if (s3_ready) begin
         s3_tag_in = s2_tag_ff;
         quot_in   = total[TOT_W-1:FRAC_SHIFT];
      end
   end

   // Result register: clamp, zero drive on done
   always_comb begin
      lim_pos = $signed(Q_W'(cfg.drive_limit));
      priority if (quot_ff > lim_pos) begin
         clamped = lim_pos;
      end else if (quot_ff < -lim_pos) begin
         clamped = -lim_pos;
      end else begin
         clamped = quot_ff;
      end
      drive_in = drive_ff;
      done_in  = done_ff;
      iter_in  = iter_ff;
      err_in   = err_ff;
      if (out_ready) begin
         drive_in = s3_tag_ff.done ? '0 : DRIVE_W'(clamped);
         done_in  = s3_tag_ff.done;
         iter_in  = s3_tag_ff.iterations;
         err_in   = s3_tag_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff  <= s1_tag_in;
      p_prod_ff  <= p_prod_in;
      d_prod_ff  <= d_prod_in;
      lo_prod_ff <= lo_prod_in;
      hi_prod_ff <= hi_prod_in;
      s2_tag_ff  <= s2_tag_in;
      iterm_ff   <= iterm_in;
      pd_sum_ff  <= pd_sum_in;
      s3_tag_ff  <= s3_tag_in;
      quot_ff    <= quot_in;
      drive_ff   <= drive_in;
      done_ff    <= done_in;
      iter_ff    <= iter_in;
      err_ff     <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_tvalid  = out_v_ff;
   assign drive       = drive_ff;
   assign done_res    = done_ff;
   assign iterations  = iter_ff;
   assign angle_error = err_ff;

   `PTC_ASSERT_IMPL(a_done_zero_drive, out_v_ff && done_ff, drive_ff == '0,
      "done result carries nonzero drive")
   `PTC_ASSERT_IMPL(a_drive_in_limit, out_v_ff && !done_ff,
      (drive_ff <= $signed({1'b0, cfg.drive_limit})) &&
      (drive_ff >= -$signed({1'b0, cfg.drive_limit})),
      "drive outside the configured limit")

endmodule

>>> rtl/pid_turn_controller_core.sv
// ----------------------------------------------------------------------------
// pid_turn_controller_core
// Heading PID turn controller with integral zone and drive clamp.
//   req_* carries one gyro sample per request with the wanted heading; a
//   request with req_tuser set starts a new turn and clears the error
//   history, the integral and the iteration count before it is processed.
//   rsp_* returns exactly one result per request, in order: left side drive
//   (the right side takes its negation), done flag, iteration count and the
//   heading error.
//   csr_* writes the gains, drive limit, integral zone, settle tolerance and
//   iteration limit; write only while no request is in flight.
//   One request is taken per cycle while the queue has room, as the front
//   end updates the turn state when it accepts a request. The back end is
//   a four-stage multiply, sum, round and clamp pipeline behind a two-entry
//   queue.
//   When the receiver holds rsp_tready low the result register holds, the
//   pipeline and queue fill up, and then req_tready drops.
//   Reset empties the pipeline, clears the turn state and reloads the
//   register defaults; req_tready stays low while reset is high.
// ----------------------------------------------------------------------------
module pid_turn_controller_core #(
   parameter int unsigned QUEUE_DEPTH = ptc_pkg::PTC_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Requests
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [47:0]                          req_tdata,  // target_angle, measured_angle
   input  logic [0:0]                           req_tuser,  // start_req
   // Results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [55:0]                          rsp_tdata,  // drive, iterations, angle_error
   output logic [0:0]                           rsp_tuser,  // done_res
   // Configuration
   input  logic                                 csr_wen,
   input  logic [ptc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ptc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ptc_pkg::*;

   ptc_cfg_type  cfg_ff, cfg_in;
   ptc_item_type front_item;
   ptc_item_type head_item;
   logic         q_full;
   logic         q_valid;
   logic         q_pop_ready;
   logic         accept;

   logic signed [DRIVE_W-1:0] drive;
   logic                      done_res;
   logic [COUNT_W-1:0]        iterations;
   logic signed [ERR_W-1:0]   angle_error;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_PROP_GAIN:   cfg_in.prop_gain        = csr_wdata[GAIN_W-1:0];
            REG_INTEG_GAIN:  cfg_in.integ_gain       = csr_wdata[GAIN_W-1:0];
            REG_DERIV_GAIN:  cfg_in.deriv_gain       = csr_wdata[GAIN_W-1:0];
            REG_DRIVE_LIMIT: cfg_in.drive_limit      = csr_wdata[LIMIT_W-1:0];
            REG_INTEG_ZONE:  cfg_in.integ_zone       = csr_wdata[ZONE_W-1:0];
            REG_SETTLE_TOL:  cfg_in.settle_tolerance = csr_wdata[ZONE_W-1:0];
            REG_ITER_LIMIT:  cfg_in.iteration_limit  = csr_wdata[COUNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain        <= PROP_GAIN_RST;
         cfg_ff.integ_gain       <= INTEG_GAIN_RST;
         cfg_ff.deriv_gain       <= DERIV_GAIN_RST;
         cfg_ff.drive_limit      <= DRIVE_LIMIT_RST;
         cfg_ff.integ_zone       <= INTEG_ZONE_RST;
         cfg_ff.settle_tolerance <= SETTLE_TOL_RST;
         cfg_ff.iteration_limit  <= ITER_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Take a request whenever the queue has room and reset is low
   assign req_tready = !q_full && !reset;
   assign accept     = req_tvalid && req_tready;

   ptc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .accept         (accept),
      .start_req      (req_tuser[0]),
      .target_angle   ($signed(req_tdata[ANGLE_W-1:0])),
      .measured_angle ($signed(req_tdata[2*ANGLE_W-1:ANGLE_W])),
      .item           (front_item)
   );

   ptc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .full      (q_full),
      .pop_ready (q_pop_ready),
      .valid     (q_valid),
      .head_item (head_item)
   );

   ptc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .item_valid  (q_valid),
      .item        (head_item),
      .item_ready  (q_pop_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .drive       (drive),
      .done_res    (done_res),
      .iterations  (iterations),
      .angle_error (angle_error)
   );

   // Pack the result fields
   assign rsp_tdata = {2'b00, angle_error, iterations, drive};
   assign rsp_tuser = done_res;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heading PID turn controller. Gyro samples go
// into the request stream and each result is compared, field by field, with
// a cycle-free predictor of the controller. Stimulus is a short directed table
// followed by random turns that converge on their target, with some noise.
// The register settings are walked between phases, and the handshakes stall
// at random on both sides, except in the last random turns, which run unstalled.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ptc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [12:0] drive;
      logic               done;
      logic [15:0]        iterations;
      logic signed [24:0] angle_error;
   } turn_result_type;

   typedef struct packed {
      logic               start;
      logic signed [23:0] target;
      logic signed [23:0] measured;
      logic               typed;
      turn_result_type    res;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [47:0]            req_tdata = '0;   // target_angle, measured_angle
   logic [0:0]             req_tuser = '0;   // start_req
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [55:0]            rsp_tdata;        // drive, iterations, angle_error
   logic [0:0]             rsp_tuser;        // done_res
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Controller state and registers as the bench sees them
   longint prev_error, error_sum, iter_count;
   longint cfg_prop, cfg_integ, cfg_deriv, cfg_limit, cfg_zone, cfg_settle, cfg_iters;

   turn_result_type pending_results[$];
   turn_result_type got_result, want_result;
   int              failures = 0;
   int              random_sent = 0;
   int unsigned     send_idle_pct = 35;
   int unsigned     recv_idle_pct = 60;
   int unsigned     cycles = 0;
   dir_row_type     directed_rows [20];
   logic [23:0]     phase_regs [7];

   pid_turn_controller_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   // Compute the result of one sample and advance the turn state
   task automatic predict_turn_step(input logic start, input logic signed [23:0] tgt,
                                    input logic signed [23:0] meas,
                                    output turn_result_type r);
      longint err, mag, deriv, pterm, iterm, dterm, q;
      logic   done;
      if (start) begin
         prev_error = 0;
         error_sum  = 0;
         iter_count = 0;
      end
      err  = longint'(tgt) - longint'(meas);
      mag  = (err < 0) ? -err : err;
      done = (mag <= cfg_settle) || (iter_count >= cfg_iters);
      q    = 0;
      if (!done) begin
         iter_count = (iter_count + 1) & 16'hFFFF;
         deriv      = err - prev_error;
         prev_error = err;
         // Accumulate inside the integral zone, clear outside it
         if (mag < cfg_zone && err != 0) begin
            error_sum = error_sum + err;
            if (error_sum > 64'sd549755813887) error_sum = 64'sd549755813887;
            if (error_sum < -64'sd549755813888) error_sum = -64'sd549755813888;
         end else begin
            error_sum = 0;
         end
         pterm = err * cfg_prop;
         dterm = deriv * cfg_deriv;
         iterm = error_sum * cfg_integ;
         if (iterm > (64'sd1 <<< 60)) iterm = 64'sd1 <<< 60;
         if (iterm < -(64'sd1 <<< 60)) iterm = -(64'sd1 <<< 60);
         // Round half up to Q.8, then clamp to the drive limit
         q = (pterm + iterm + dterm + 32768) >>> 16;
         if (q > cfg_limit) q = cfg_limit;
         if (q < -cfg_limit) q = -cfg_limit;
      end
      r.drive       = q[12:0];
      r.done        = done;
      r.iterations  = iter_count[15:0];
      r.angle_error = err[24:0];
   endtask

   // Offer one request, wait for acceptance and queue its expected result
   task automatic send_request(input logic start, input logic signed [23:0] tgt,
                               input logic signed [23:0] meas, input logic typed,
                               input turn_result_type typed_res);
      turn_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {meas, tgt};
      req_tuser  = start;
      do @(posedge clock); while (!req_tready);
      predict_turn_step(start, tgt, meas, predicted);
      pending_results.push_back(typed ? typed_res : predicted);
      @(negedge clock);
   endtask

   // Drain, then write all seven registers from phase_regs
   task automatic program_registers();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      for (int r = 0; r < 7; r++) begin
         csr_wen   = 1'b1;
         csr_index = ptc_reg_type'(r);
         csr_wdata = phase_regs[r];
         case (ptc_reg_type'(r))
            REG_PROP_GAIN:   cfg_prop   = longint'(phase_regs[r]);
            REG_INTEG_GAIN:  cfg_integ  = longint'(phase_regs[r]);
            REG_DERIV_GAIN:  cfg_deriv  = longint'(phase_regs[r]);
            REG_DRIVE_LIMIT: cfg_limit  = longint'(phase_regs[r][11:0]);
            REG_INTEG_ZONE:  cfg_zone   = longint'(phase_regs[r][22:0]);
            REG_SETTLE_TOL:  cfg_settle = longint'(phase_regs[r][22:0]);
            REG_ITER_LIMIT:  cfg_iters  = longint'(phase_regs[r][15:0]);
            default: ;
         endcase
         @(negedge clock);
      end
      csr_wen = 1'b0;
   endtask

   function automatic longint pick_angle();
      case ($urandom_range(3))
         0: return longint'($urandom_range(0, 16777215)) - 8388608;
         1: return longint'($urandom_range(0, 16384)) - 8192;
         2: return $urandom_range(1) ? 64'sd8388607 : -64'sd8388608;
         default: return longint'($urandom_range(0, 400)) - 200;
      endcase
   endfunction

   // Random turns: mostly a start then samples closing on the target,
   // some turns without a start, and some lone noise samples
   task automatic run_turns(input int count);
      longint tgt, meas, e;
      int     len, kind, sent;
      logic   start;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(9);
         tgt  = pick_angle();
         meas = pick_angle();
         len  = (kind == 0) ? 1 : $urandom_range(3, 25);
         for (int k = 0; k < len && sent < count; k++) begin
            if (random_sent < 217) begin
               send_idle_pct = 35;
               recv_idle_pct = 60;
            end else if (random_sent < 434) begin
               send_idle_pct = 60;
               recv_idle_pct = 35;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            case (kind)
               0:       start = 1'($urandom_range(1));
               1:       start = 1'b0;
               default: start = (k == 0);
            endcase
            send_request(start, tgt[23:0], meas[23:0], 1'b0, '0);
            sent++;
            random_sent++;
            // Move the heading toward the target with some jitter
            e    = tgt - meas;
            meas = meas + (e * longint'($urandom_range(2, 7))) / 8
                   + longint'($urandom_range(0, 600)) - 300;
            if (meas > 8388607) meas = 8388607;
            if (meas < -8388608) meas = -8388608;
            if ($urandom_range(7) == 0) tgt = pick_angle();
         end
      end
   endtask

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result.drive       = rsp_tdata[12:0];
         got_result.iterations  = rsp_tdata[28:13];
         got_result.angle_error = rsp_tdata[53:29];
         got_result.done        = rsp_tuser[0];
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected: drive %0d done %0b", $time,
                     got_result.drive, got_result.done);
            failures++;
         end else begin
            want_result = pending_results.pop_front();
            if (got_result.drive !== want_result.drive) begin
               $display("%0t: drive expected %0d, actual %0d", $time,
                        want_result.drive, got_result.drive);
               failures++;
            end
            if (got_result.done !== want_result.done) begin
               $display("%0t: done expected %0b, actual %0b", $time,
                        want_result.done, got_result.done);
               failures++;
            end
            if (got_result.iterations !== want_result.iterations) begin
               $display("%0t: iterations expected %0d, actual %0d", $time,
                        want_result.iterations, got_result.iterations);
               failures++;
            end
            if (got_result.angle_error !== want_result.angle_error) begin
               $display("%0t: angle_error expected %0d, actual %0d", $time,
                        want_result.angle_error, got_result.angle_error);
               failures++;
            end
         end
      end
   end

   initial begin
      // start, target, measured, typed, {drive, done, iterations, angle_error}
      directed_rows = '{
         '{1'b1, 24'sd0, 24'sd0, 1'b1, '{13'sd0, 1'b1, 16'd0, 25'sd0}},
         '{1'b0, 24'sd8388607, -24'sd8388608, 1'b1,
           '{13'sd1536, 1'b0, 16'd1, 25'sd16777215}},
         '{1'b0, -24'sd8388608, 24'sd8388607, 1'b1,
           '{-13'sd1536, 1'b0, 16'd2, -25'sd16777215}},
         '{1'b0, 24'sd128, 24'sd0, 1'b1, '{13'sd0, 1'b1, 16'd2, 25'sd128}},
         '{1'b0, 24'sd0, 24'sd128, 1'b1, '{13'sd0, 1'b1, 16'd2, -25'sd128}},
         '{1'b0, 24'sd129, 24'sd0, 1'b0, '0},
         '{1'b0, 24'sd0, 24'sd129, 1'b0, '0},
         '{1'b0, 24'sd4095, 24'sd0, 1'b0, '0},
         '{1'b0, 24'sd4096, 24'sd0, 1'b0, '0},
         '{1'b0, -24'sd4095, 24'sd0, 1'b0, '0},
         // done, then control resumes on the next sample
         '{1'b0, 24'sd100, 24'sd50, 1'b1, '{13'sd0, 1'b1, 16'd7, 25'sd50}},
         '{1'b0, 24'sd5000, 24'sd0, 1'b0, '0},
         '{1'b0, 24'shAAAAAA, 24'sh555555, 1'b0, '0},
         '{1'b0, 24'sh555555, 24'shAAAAAA, 1'b0, '0},
         '{1'b1, 24'sd64, 24'sd0, 1'b1, '{13'sd0, 1'b1, 16'd0, 25'sd64}},
         '{1'b1, 24'sd0, 24'sd8388607, 1'b1,
           '{-13'sd1536, 1'b0, 16'd1, -25'sd8388607}},
         '{1'b0, 24'sd1000, 24'sd0, 1'b0, '0},
         '{1'b0, 24'sd1000, 24'sd0, 1'b0, '0},
         '{1'b1, 24'sd1, 24'sd0, 1'b1, '{13'sd0, 1'b1, 16'd0, 25'sd1}},
         '{1'b0, 24'sd0, -24'sd1, 1'b1, '{13'sd0, 1'b1, 16'd0, 25'sd1}}
      };
      prev_error = 0;
      error_sum  = 0;
      iter_count = 0;
      cfg_prop   = longint'(PROP_GAIN_RST);
      cfg_integ  = longint'(INTEG_GAIN_RST);
      cfg_deriv  = longint'(DERIV_GAIN_RST);
      cfg_limit  = longint'(DRIVE_LIMIT_RST);
      cfg_zone   = longint'(INTEG_ZONE_RST);
      cfg_settle = longint'(SETTLE_TOL_RST);
      cfg_iters  = longint'(ITER_LIMIT_RST);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Register defaults
      foreach (directed_rows[i])
         send_request(directed_rows[i].start, directed_rows[i].target,
                      directed_rows[i].measured, directed_rows[i].typed,
                      directed_rows[i].res);
      run_turns(150);

      // Largest gains, drive limit above the nominal range, no tolerance.
      // Integral saturation lies beyond what the iteration limit allows.
      phase_regs = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd4095,
                     24'd8388607, 24'd0, 24'd65535};
      program_registers();
      run_turns(130);

      // All zero: the zero iteration limit reports done on every sample
      phase_regs = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
      program_registers();
      run_turns(50);

      // Short iteration limit so turns give up often
      phase_regs = '{24'($urandom_range(0, 131072)), 24'($urandom_range(0, 16384)),
                     24'($urandom_range(0, 65536)), 24'd3072,
                     24'($urandom_range(0, 20000)), 24'($urandom_range(0, 2000)),
                     24'd8};
      program_registers();
      run_turns(160);

      // Anything goes
      phase_regs = '{24'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom_range(0, 4095)), 24'($urandom_range(0, 8388607)),
                     24'($urandom_range(0, 4000)), 24'($urandom_range(1, 60))};
      program_registers();
      run_turns(160);

      // Drain and let the pipeline settle
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
